>>> sv/rrb_pkg.sv
package rrb_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ICPT_CAP   = 3'd0,
		REG_INFIL_COEF = 3'd1,
		REG_INFIL_SHP  = 3'd2,
		REG_SOIL_CAP   = 3'd3,
		REG_IFLOW_FRAC = 3'd4,
		REG_RECH_FRAC  = 3'd5,
		REG_BASE_FRAC  = 3'd6
	} reg_idx_t;

	localparam logic [19:0] RST_ICPT_CAP   = 20'd98304;
	localparam logic [25:0] RST_INFIL_COEF = 26'd13107200;
	localparam logic [20:0] RST_INFIL_SHP  = 21'd196608;
	localparam logic [26:0] RST_SOIL_CAP   = 27'd19660800;
	localparam logic [16:0] RST_IFLOW_FRAC = 17'd32768;
	localparam logic [16:0] RST_RECH_FRAC  = 17'd6554;
	localparam logic [16:0] RST_BASE_FRAC  = 17'd6554;

	localparam logic [27:0] MAX28 = 28'hFFFFFFF;
	localparam logic [31:0] MAX32 = 32'hFFFFFFFF;

	typedef struct packed {
		logic [25:0] rain;
		logic [25:0] potential_evap;
	} in_t;

	typedef struct packed {
		logic [31:0] total_runoff;
		logic [26:0] total_evap;
		logic [25:0] interception;
		logic [25:0] throughfall;
		logic [25:0] infiltration;
		logic [25:0] direct_runoff;
		logic [25:0] interflow;
		logic [27:0] recharge;
		logic [26:0] soil_moisture_out;
		logic [31:0] groundwater_out;
		logic [25:0] soil_evap;
		logic [31:0] baseflow;
	} out_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_FIRST, OP_PREP, OP_RDIV, OP_XMUL, OP_EXPA, OP_EXPB,
		OP_EXPC, OP_EXPD, OP_EXPE, OP_EXPF, OP_LIMM, OP_INFIL, OP_AMUL, OP_INTER,
		OP_BMUL, OP_RECH, OP_SOIL, OP_ET, OP_GMUL, OP_BASE, OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIRST, ST_PREP, ST_DIV1, ST_RDIV, ST_XMUL, ST_EXPA, ST_EXPB,
		ST_EXPC, ST_EXPD, ST_EXPE, ST_EXPF, ST_LIMM, ST_INFIL, ST_AMUL, ST_INTER,
		ST_BMUL, ST_RECH, ST_SOIL, ST_DIV2, ST_ET, ST_GMUL, ST_BASE, ST_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic cap_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> sv/rainfall_runoff_bucket_step_top.sv
// Daily bucket-model step. Each input beat on in_data carries one day of rain and
// potential evaporation; the block answers with exactly one result beat on
// out_data holding the fluxes and the updated soil and groundwater stores.
// Both channels use valid/stall; a beat moves when valid is high and stall is low.
// The configuration registers are written through cfg_wr_en, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. An unknown index is ignored. One item is
// worked on at a time: in_stall is low only while the block waits for an item.
// The first item after reset only loads the stores (half the soil capacity,
// empty groundwater) and returns zeros but for the loaded soil_moisture_out.
// The bit-serial divider dominates: it runs twice per item, once for the
// fill fraction and once for the evaporation cap, and is skipped when the soil
// capacity is zero. A single 33x33 multiplier serves all other products.
// Results sit in an output register, so a stalled receiver does not hold off
// the next item's work; only its final write waits until the register is free.
// Reset restores the configuration registers and stores to their default values and empties the pipeline.
module rainfall_runoff_bucket_step_top #(
	parameter int FRAC_BITS    = 16,
	parameter int EXP_SEGMENTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rrb_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rrb_pkg::out_t                  out_data,
	input  logic                           cfg_wr_en,
	input  logic [rrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rrb_pkg::*;

	cmd_t    cmd;
	status_t status;

	rrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rrb_dp #(
		.FRAC_BITS    (FRAC_BITS),
		.EXP_SEGMENTS (EXP_SEGMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

endmodule

>>> sv/rrb_div.sv
module rrb_div #(
	parameter int NW = 47,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quot,
	output logic          done
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] qr_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, qr_q[NW-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qr_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			qr_q  <= {qr_q[NW-2:0], ge};
		end
	end

	assign quot = qr_q;
	assign done = done_q;

endmodule

>>> sv/rrb_dp.sv
module rrb_dp #(
	parameter int FRAC_BITS    = 16,
	parameter int EXP_SEGMENTS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrb_pkg::cmd_t                    cmd,
	output rrb_pkg::status_t                 status,
	input  rrb_pkg::in_t                     in_data,
	output rrb_pkg::out_t                    out_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             cfg_wr_en,
	input  logic [rrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rrb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rrb_pkg::*;

	localparam int RW = FRAC_BITS + 1;
	localparam int NW = 31 + FRAC_BITS;
	localparam int SW = $clog2(EXP_SEGMENTS + 1);
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [RW-1:0]    ONE_R = RW'(ONE_L);
	localparam logic [MUL_W-1:0] ONE_M = MUL_W'(ONE_L);

	function automatic logic [63:0] div_small(logic [63:0] v, int k);
		logic [63:0] r;
		case (k)
			2:       r = v / 2;
			3:       r = v / 3;
			4:       r = v / 4;
			5:       r = v / 5;
			6:       r = v / 6;
			7:       r = v / 7;
			8:       r = v / 8;
			9:       r = v / 9;
			10:      r = v / 10;
			11:      r = v / 11;
			12:      r = v / 12;
			default: r = v;
		endcase
		return r;
	endfunction

	// Ratio between neighboring table entries, exp(-1/segments), by its series.
	function automatic logic [63:0] exp_ratio();
		logic [63:0] d;
		logic [63:0] term;
		logic [63:0] q;
		d    = ((64'd1 << 32) + 64'(EXP_SEGMENTS / 2)) / 64'(EXP_SEGMENTS);
		term = 64'd1 << 32;
		q    = 64'd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = div_small((term * d) >> 32, k);
			if (k % 2 == 1) q = q - term;
			else q = q + term;
		end
		return q;
	endfunction

	function automatic logic [63:0] seg_val(int idx);
		logic [63:0] q;
		logic [63:0] v;
		q = exp_ratio();
		v = 64'd1 << 32;
		for (int k = 1; k <= idx; k++) v = (v * q + (64'd1 << 31)) >> 32;
		return v;
	endfunction

	function automatic logic [63:0] int_val(int n);
		logic [63:0] last;
		logic [63:0] v;
		last = seg_val(EXP_SEGMENTS);
		v    = 64'd1 << 32;
		for (int k = 1; k <= n; k++) v = (v * last + (64'd1 << 31)) >> 32;
		return v;
	endfunction

	logic [MUL_W-1:0] seg_tab [EXP_SEGMENTS+1];
	logic [MUL_W-1:0] int_tab [32];

	for (genvar g = 0; g <= EXP_SEGMENTS; g++) begin : g_seg
		localparam logic [63:0] SEGV = seg_val(g);
		assign seg_tab[g] = SEGV[MUL_W-1:0];
	end

	for (genvar g = 0; g < 32; g++) begin : g_int
		localparam logic [63:0] INTV = int_val(g);
		assign int_tab[g] = INTV[MUL_W-1:0];
	end

	logic [19:0] icap_q;
	logic [25:0] icoef_q;
	logic [20:0] ishape_q;
	logic [26:0] scap_q;
	logic [16:0] ifrac_q;
	logic [16:0] rfrac_q;
	logic [16:0] bfrac_q;

	logic        first_q;
	logic [26:0] soil_q;
	logic [31:0] gw_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [25:0]   rain_q;
	logic [25:0]   pet_q;
	logic [RW-1:0] r_q;
	logic [20:0]   x_q;
	logic [SW-1:0] s_q;
	logic [FRAC_BITS-1:0] w_q;
	logic [MUL_W-1:0] v_q;
	logic [MUL_W-1:0] e_q;
	logic [25:0]   icpt_q;
	logic [25:0]   thru_q;
	logic [25:0]   infil_q;
	logic [25:0]   direct_q;
	logic [25:0]   inter_q;
	logic [27:0]   rech_q;
	logic [26:0]   sms_q;
	logic [25:0]   et_q;
	logic [31:0]   gws_q;
	logic [31:0]   bas_q;
	logic [31:0]   tot_q;
	logic [PROD_W-1:0] prod_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod_f;
	logic [PROD_W-1:0] prod_32;
	logic [MUL_W-1:0]  ifrac_c;
	logic [MUL_W-1:0]  rfrac_c;
	logic [MUL_W-1:0]  bfrac_c;
	logic              cap_zero;
	logic [MUL_W-1:0]  seg_a;
	logic [MUL_W-1:0]  seg_b;
	logic [4:0]        int_idx;
	logic              x_big;
	logic              x_small;
	logic [63:0]       p_c;
	logic [25:0]       icpt_c;
	logic [25:0]       icap_w;
	logic [25:0]       lim_c;
	logic [25:0]       infil_c;
	logic [25:0]       rech0_c;
	logic [25:0]       smf_c;
	logic [27:0]       sum_c;
	logic [27:0]       over_c;
	logic [28:0]       rsum_c;
	logic [NW-1:0]     etcap_c;
	logic [25:0]       et_c;
	logic [26:0]       news_c;
	logic [32:0]       gsum_c;
	logic [31:0]       bas_c;
	logic [33:0]       tsum_c;
	logic [30:0]       sms10_c;

	logic          div_start;
	logic [NW-1:0] div_num;
	logic [NW-1:0] div_quot;
	logic          div_done;

	rrb_div #(.NW(NW), .DW(27)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (scap_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	assign cap_zero = scap_q == 27'd0;
	assign prod_f   = prod_q >> FRAC_BITS;
	assign prod_32  = prod_q >> 32;
	assign ifrac_c  = (MUL_W'(ifrac_q) > ONE_M) ? ONE_M : MUL_W'(ifrac_q);
	assign rfrac_c  = (MUL_W'(rfrac_q) > ONE_M) ? ONE_M : MUL_W'(rfrac_q);
	assign bfrac_c  = (MUL_W'(bfrac_q) > ONE_M) ? ONE_M : MUL_W'(bfrac_q);

	assign seg_a    = seg_tab[s_q];
	assign seg_b    = seg_tab[s_q + SW'(1)];
	assign int_idx  = 5'(64'(x_q) >> FRAC_BITS);
	assign x_big    = 64'(x_q) >= (64'd32 << FRAC_BITS);
	assign x_small  = 64'(x_q) < ONE_L;
	assign p_c      = (64'(x_q) & (ONE_L - 64'd1)) * 64'(EXP_SEGMENTS);

	assign icap_w   = 26'(icap_q);
	assign icpt_c   = (rain_q < icap_w && rain_q < pet_q) ? rain_q :
		((icap_w < pet_q) ? icap_w : pet_q);
	assign lim_c    = 26'(prod_32);
	assign infil_c  = (lim_c < thru_q) ? lim_c : thru_q;
	assign rech0_c  = 26'(prod_f);
	assign smf_c    = infil_q - inter_q - rech0_c;
	assign sum_c    = 28'(soil_q) + 28'(smf_c);
	assign over_c   = sum_c - 28'(scap_q);
	assign rsum_c   = 29'(rech0_c) + 29'(over_c);
	assign etcap_c  = cap_zero ? '0 : div_quot;
	assign et_c     = (etcap_c < NW'(pet_q)) ? 26'(etcap_c) : pet_q;
	assign news_c   = (sms_q > 27'(et_c)) ? (sms_q - 27'(et_c)) : 27'd0;
	assign gsum_c   = 33'(gw_q) + 33'(rech_q);
	assign bas_c    = 32'(prod_f);
	assign tsum_c   = 34'(direct_q) + 34'(inter_q) + 34'(bas_c);
	assign sms10_c  = 31'(sms_q) * 31'd10;

	assign div_start = !cap_zero && (cmd.op == OP_PREP || cmd.op == OP_SOIL);
	assign div_num   = (cmd.op == OP_PREP) ? (NW'(soil_q) << FRAC_BITS) :
		(NW'(sms10_c) << FRAC_BITS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_XMUL: begin
				mul_a = MUL_W'(ishape_q);
				mul_b = MUL_W'(r_q);
			end
			OP_EXPC: begin
				mul_a = seg_a - seg_b;
				mul_b = MUL_W'(w_q);
			end
			OP_EXPE: begin
				mul_a = int_tab[int_idx];
				mul_b = v_q;
			end
			OP_LIMM: begin
				mul_a = MUL_W'(icoef_q);
				mul_b = e_q;
			end
			OP_INFIL: begin
				mul_a = ifrac_c;
				mul_b = MUL_W'(r_q);
			end
			OP_AMUL: begin
				mul_a = MUL_W'(prod_f);
				mul_b = MUL_W'(infil_q);
			end
			OP_INTER: begin
				mul_a = rfrac_c;
				mul_b = MUL_W'(r_q);
			end
			OP_BMUL: begin
				mul_a = MUL_W'(prod_f);
				mul_b = MUL_W'(infil_q - inter_q);
			end
			OP_GMUL: begin
				mul_a = bfrac_c;
				mul_b = MUL_W'(gws_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icap_q      <= RST_ICPT_CAP;
			icoef_q     <= RST_INFIL_COEF;
			ishape_q    <= RST_INFIL_SHP;
			scap_q      <= RST_SOIL_CAP;
			ifrac_q     <= RST_IFLOW_FRAC;
			rfrac_q     <= RST_RECH_FRAC;
			bfrac_q     <= RST_BASE_FRAC;
			soil_q      <= RST_SOIL_CAP >> 1;
			gw_q        <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (reg_idx_t'(cfg_index))
					REG_ICPT_CAP:   icap_q   <= cfg_data[19:0];
					REG_INFIL_COEF: icoef_q  <= cfg_data[25:0];
					REG_INFIL_SHP:  ishape_q <= cfg_data[20:0];
					REG_SOIL_CAP:   scap_q   <= cfg_data[26:0];
					REG_IFLOW_FRAC: ifrac_q  <= cfg_data[16:0];
					REG_RECH_FRAC:  rfrac_q  <= cfg_data[16:0];
					REG_BASE_FRAC:  bfrac_q  <= cfg_data[16:0];
					default: begin
					end
				endcase
			end
			case (cmd.op)
				OP_FIRST: begin
					soil_q  <= scap_q >> 1;
					gw_q    <= '0;
					first_q <= 1'b0;
				end
				OP_ET:   soil_q <= news_c;
				OP_BASE: gw_q   <= gws_q - bas_c;
				default: begin
				end
			endcase
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (cmd.op)
			OP_LOAD: begin
				rain_q <= in_data.rain;
				pet_q  <= in_data.potential_evap;
			end
			OP_FIRST: begin
				icpt_q   <= '0;
				thru_q   <= '0;
				infil_q  <= '0;
				direct_q <= '0;
				inter_q  <= '0;
				rech_q   <= '0;
				et_q     <= '0;
				bas_q    <= '0;
				tot_q    <= '0;
				gws_q    <= '0;
				sms_q    <= scap_q >> 1;
			end
			OP_PREP: begin
				icpt_q <= icpt_c;
				thru_q <= rain_q - icpt_c;
				r_q    <= '0;
			end
			OP_RDIV: r_q <= (div_quot > NW'(ONE_L)) ? ONE_R : RW'(div_quot);
			OP_EXPA: x_q <= 21'(prod_f);
			OP_EXPB: begin
				s_q <= SW'(p_c >> FRAC_BITS);
				w_q <= FRAC_BITS'(p_c & (ONE_L - 64'd1));
			end
			OP_EXPD: v_q <= seg_a - MUL_W'(prod_f);
			OP_EXPF: begin
				if (x_big) begin
					e_q <= '0;
				end else if (x_small) begin
					e_q <= v_q;
				end else begin
					e_q <= MUL_W'(prod_32);
				end
			end
			OP_INFIL: begin
				infil_q  <= infil_c;
				direct_q <= thru_q - infil_c;
			end
			OP_INTER: inter_q <= 26'(prod_f);
			OP_RECH: begin
				if (sum_c > 28'(scap_q)) begin
					rech_q <= (rsum_c > 29'(MAX28)) ? MAX28 : 28'(rsum_c);
					sms_q  <= scap_q;
				end else begin
					rech_q <= 28'(rech0_c);
					sms_q  <= 27'(sum_c);
				end
			end
			OP_ET: begin
				et_q  <= et_c;
				sms_q <= news_c;
				gws_q <= (gsum_c > 33'(MAX32)) ? MAX32 : 32'(gsum_c);
			end
			OP_BASE: begin
				bas_q <= bas_c;
				tot_q <= (tsum_c > 34'(MAX32)) ? MAX32 : 32'(tsum_c);
			end
			OP_EMIT: begin
				out_q.total_runoff      <= tot_q;
				out_q.total_evap        <= 27'(et_q) + 27'(icpt_q);
				out_q.interception      <= icpt_q;
				out_q.throughfall       <= thru_q;
				out_q.infiltration      <= infil_q;
				out_q.direct_runoff     <= direct_q;
				out_q.interflow         <= inter_q;
				out_q.recharge          <= rech_q;
				out_q.soil_moisture_out <= sms_q;
				out_q.groundwater_out   <= first_q ? 32'd0 : gw_q;
				out_q.soil_evap         <= et_q;
				out_q.baseflow          <= bas_q;
			end
			default: begin
			end
		endcase
	end

	assign status.first    = first_q;
	assign status.cap_zero = cap_zero;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |=> out_valid_q)
		else $error("emitted result not presented");

	a_gw_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_BASE |=> gw_q <= $past(gws_q))
		else $error("baseflow exceeded groundwater");

	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RDIV |=> r_q <= ONE_R)
		else $error("fill fraction above one");

endmodule

>>> sv/rrb_ctrl.sv
module rrb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rrb_pkg::status_t status,
	output rrb_pkg::cmd_t    cmd
);
	import rrb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = status.first ? ST_FIRST : ST_PREP;
			end
			ST_FIRST: state_d = ST_DONE;
			ST_PREP:  state_d = status.cap_zero ? ST_XMUL : ST_DIV1;
			ST_DIV1: begin
				if (status.div_done) state_d = ST_RDIV;
			end
			ST_RDIV:  state_d = ST_XMUL;
			ST_XMUL:  state_d = ST_EXPA;
			ST_EXPA:  state_d = ST_EXPB;
			ST_EXPB:  state_d = ST_EXPC;
			ST_EXPC:  state_d = ST_EXPD;
			ST_EXPD:  state_d = ST_EXPE;
			ST_EXPE:  state_d = ST_EXPF;
			ST_EXPF:  state_d = ST_LIMM;
			ST_LIMM:  state_d = ST_INFIL;
			ST_INFIL: state_d = ST_AMUL;
			ST_AMUL:  state_d = ST_INTER;
			ST_INTER: state_d = ST_BMUL;
			ST_BMUL:  state_d = ST_RECH;
			ST_RECH:  state_d = ST_SOIL;
			ST_SOIL:  state_d = status.cap_zero ? ST_ET : ST_DIV2;
			ST_DIV2: begin
				if (status.div_done) state_d = ST_ET;
			end
			ST_ET:    state_d = ST_GMUL;
			ST_GMUL:  state_d = ST_BASE;
			ST_BASE:  state_d = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_FIRST: cmd.op = OP_FIRST;
			ST_PREP:  cmd.op = OP_PREP;
			ST_RDIV:  cmd.op = OP_RDIV;
			ST_XMUL:  cmd.op = OP_XMUL;
			ST_EXPA:  cmd.op = OP_EXPA;
			ST_EXPB:  cmd.op = OP_EXPB;
			ST_EXPC:  cmd.op = OP_EXPC;
			ST_EXPD:  cmd.op = OP_EXPD;
			ST_EXPE:  cmd.op = OP_EXPE;
			ST_EXPF:  cmd.op = OP_EXPF;
			ST_LIMM:  cmd.op = OP_LIMM;
			ST_INFIL: cmd.op = OP_INFIL;
			ST_AMUL:  cmd.op = OP_AMUL;
			ST_INTER: cmd.op = OP_INTER;
			ST_BMUL:  cmd.op = OP_BMUL;
			ST_RECH:  cmd.op = OP_RECH;
			ST_SOIL:  cmd.op = OP_SOIL;
			ST_ET:    cmd.op = OP_ET;
			ST_GMUL:  cmd.op = OP_GMUL;
			ST_BASE:  cmd.op = OP_BASE;
			ST_DONE: begin
				if (status.out_free) cmd.op = OP_EMIT;
			end
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

>>> tb/tb_rainfall_runoff_bucket_step_top.sv
`timescale 1ns / 1ps

module tb_rainfall_runoff_bucket_step_top;
	import rrb_pkg::*;

	localparam int FRAC          = 16;
	localparam int SEGS          = 64;
	localparam int INT_LIMIT     = 32;
	localparam int NUM_REGS      = 7;
	localparam int SETTLE_CYCLES = 250;
	localparam int WATCHDOG_MAX  = 20000;
	localparam int HOLD_CYCLES   = 600;
	localparam longint unsigned ONE_Q   = 64'd1 << FRAC;
	localparam longint unsigned EXP_ONE = 64'd1 << 32;
	localparam longint unsigned HALF32  = 64'd1 << 31;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rainfall_runoff_bucket_step_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state.
	longint unsigned bucket_regs [NUM_REGS];
	longint unsigned soil_level;
	longint unsigned ground_level;
	bit              awaiting_first;
	longint unsigned seg_exp [SEGS+1];
	longint unsigned whole_exp [INT_LIMIT];

	in_t  day_queue [$];
	out_t flux_queue [$];

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request;
	int  hold_count = 0;
	bit  in_taken = 1'b0;
	bit  failed = 1'b0;
	int  watchdog = 0;
	int  days_sent = 0;
	int  results_seen = 0;
	int  mismatches = 0;

	always #1 clk = ~clk;

	function automatic longint unsigned min_u(longint unsigned a, longint unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic int reg_width(int idx);
		case (idx)
			REG_ICPT_CAP:   return 20;
			REG_INFIL_COEF: return 26;
			REG_INFIL_SHP:  return 21;
			REG_SOIL_CAP:   return 27;
			default:        return 17;
		endcase
	endfunction

	function automatic void build_exp_tables();
		longint unsigned step;
		longint unsigned term;
		longint unsigned ratio;
		step  = (EXP_ONE + SEGS / 2) / SEGS;
		term  = EXP_ONE;
		ratio = EXP_ONE;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * step) >> 32) / k;
			if (k % 2 == 1) ratio = ratio - term;
			else ratio = ratio + term;
		end
		seg_exp[0] = EXP_ONE;
		for (int k = 1; k <= SEGS; k++)
			seg_exp[k] = (seg_exp[k-1] * ratio + HALF32) >> 32;
		whole_exp[0] = EXP_ONE;
		for (int k = 1; k < INT_LIMIT; k++)
			whole_exp[k] = (whole_exp[k-1] * seg_exp[SEGS] + HALF32) >> 32;
	endfunction

	function automatic longint unsigned decay(longint unsigned x);
		longint unsigned whole;
		longint unsigned pos;
		longint unsigned seg;
		longint unsigned wt;
		longint unsigned v;
		whole = x >> FRAC;
		pos   = (x & (ONE_Q - 1)) * SEGS;
		seg   = pos >> FRAC;
		wt    = pos & (ONE_Q - 1);
		if (whole >= INT_LIMIT) return 0;
		v = seg_exp[seg] - (((seg_exp[seg] - seg_exp[seg+1]) * wt) >> FRAC);
		if (whole == 0) return v;
		return (whole_exp[whole] * v) >> 32;
	endfunction

	function automatic out_t bucket_step(in_t day);
		out_t            res;
		longint unsigned cap;
		longint unsigned fill, icpt, thru, infil, direct, inter, rech, gain;
		longint unsigned sms, etcap, et, gw, bas, tot, f_if, f_re, f_bf;
		res  = '0;
		cap  = bucket_regs[REG_SOIL_CAP];
		f_if = min_u(bucket_regs[REG_IFLOW_FRAC], ONE_Q);
		f_re = min_u(bucket_regs[REG_RECH_FRAC], ONE_Q);
		f_bf = min_u(bucket_regs[REG_BASE_FRAC], ONE_Q);
		if (awaiting_first) begin
			awaiting_first = 1'b0;
			soil_level     = cap / 2;
			ground_level   = 0;
			res.soil_moisture_out = 27'(soil_level);
			return res;
		end
		fill   = (cap != 0) ? min_u((soil_level << FRAC) / cap, ONE_Q) : 0;
		icpt   = min_u(day.rain, min_u(bucket_regs[REG_ICPT_CAP], day.potential_evap));
		thru   = day.rain - icpt;
		infil  = min_u((bucket_regs[REG_INFIL_COEF]
			* decay((bucket_regs[REG_INFIL_SHP] * fill) >> FRAC)) >> 32, thru);
		direct = thru - infil;
		inter  = (((f_if * fill) >> FRAC) * infil) >> FRAC;
		rech   = (((f_re * fill) >> FRAC) * (infil - inter)) >> FRAC;
		gain   = infil - inter - rech;
		sms    = soil_level + gain;
		if (sms > cap) begin
			rech = rech + (sms - cap);
			sms  = cap;
		end
		rech  = min_u(rech, 64'h0FFF_FFFF);
		etcap = (cap != 0) ? ((10 * sms) << FRAC) / cap : 0;
		et    = min_u(etcap, day.potential_evap);
		sms   = (sms > et) ? sms - et : 0;
		soil_level = sms;
		gw  = min_u(ground_level + rech, 64'hFFFF_FFFF);
		bas = (f_bf * gw) >> FRAC;
		gw  = gw - bas;
		ground_level = gw;
		tot = min_u(direct + inter + bas, 64'hFFFF_FFFF);
		res.total_runoff      = 32'(tot);
		res.total_evap        = 27'(et + icpt);
		res.interception      = 26'(icpt);
		res.throughfall       = 26'(thru);
		res.infiltration      = 26'(infil);
		res.direct_runoff     = 26'(direct);
		res.interflow         = 26'(inter);
		res.recharge          = 28'(rech);
		res.soil_moisture_out = 27'(sms);
		res.groundwater_out   = 32'(gw);
		res.soil_evap         = 26'(et);
		res.baseflow          = 32'(bas);
		return res;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failed = 1'b1;
			mismatches++;
		end
	endtask

	// Predictor, checker and watchdog, all sampled at the rising edge.
	always @(posedge clk) begin
		out_t want;
		bit   moved;
		moved = 1'b0;
		in_taken <= in_valid && !in_stall;
		if (arst_n && cfg_wr_en && cfg_index < NUM_REGS)
			bucket_regs[cfg_index] = cfg_data & ((64'd1 << reg_width(cfg_index)) - 1);
		if (arst_n && in_valid && !in_stall) begin
			flux_queue.push_back(bucket_step(in_data));
			days_sent++;
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			results_seen++;
			if (flux_queue.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time, out_data);
				failed = 1'b1;
			end else begin
				want = flux_queue.pop_front();
				check_field("total_runoff", want.total_runoff, out_data.total_runoff);
				check_field("total_evap", want.total_evap, out_data.total_evap);
				check_field("interception", want.interception, out_data.interception);
				check_field("throughfall", want.throughfall, out_data.throughfall);
				check_field("infiltration", want.infiltration, out_data.infiltration);
				check_field("direct_runoff", want.direct_runoff, out_data.direct_runoff);
				check_field("interflow", want.interflow, out_data.interflow);
				check_field("recharge", want.recharge, out_data.recharge);
				check_field("soil_moisture_out", want.soil_moisture_out,
					out_data.soil_moisture_out);
				check_field("groundwater_out", want.groundwater_out, out_data.groundwater_out);
				check_field("soil_evap", want.soil_evap, out_data.soil_evap);
				check_field("baseflow", want.baseflow, out_data.baseflow);
			end
		end
		if (!arst_n || moved || cfg_wr_en) begin
			watchdog = 0;
		end else begin
			watchdog++;
			if (watchdog >= WATCHDOG_MAX) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_MAX);
				$display("** rainfall_runoff_bucket_step_top: FAILED **");
				$finish;
			end
		end
	end

	// Sender.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (day_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			in_valid <= 1'b1;
			in_data  <= day_queue.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver; a hold request stalls it for a long stretch.
	always @(negedge clk) begin
		if (hold_request && hold_count == 0) hold_count = HOLD_CYCLES;
		if (hold_count > 0) begin
			hold_count--;
			out_stall <= 1'b1;
			if (hold_count == 0) hold_request = 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task automatic write_reg(reg_idx_t idx, longint unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all(longint unsigned v0, longint unsigned v1, longint unsigned v2,
		longint unsigned v3, longint unsigned v4, longint unsigned v5, longint unsigned v6);
		write_reg(REG_ICPT_CAP, v0);
		write_reg(REG_INFIL_COEF, v1);
		write_reg(REG_INFIL_SHP, v2);
		write_reg(REG_SOIL_CAP, v3);
		write_reg(REG_IFLOW_FRAC, v4);
		write_reg(REG_RECH_FRAC, v5);
		write_reg(REG_BASE_FRAC, v6);
	endtask

	task automatic add_day(longint unsigned rain, longint unsigned pet);
		in_t d;
		d.rain           = 26'(rain);
		d.potential_evap = 26'(pet);
		day_queue.push_back(d);
	endtask

	task automatic add_random_days(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       add_day($urandom_range(0, 26'h3FFFFFF), $urandom_range(0, 26'h3FFFFFF));
				1:       add_day(0, $urandom_range(0, 12 << 16));
				2:       add_day($urandom_range(0, 26'h3FFFFFF), $urandom_range(0, 4 << 16));
				default: add_day($urandom_range(0, 90 << 16), $urandom_range(0, 12 << 16));
			endcase
		end
	endtask

	task automatic drain();
		wait (day_queue.size() == 0 && !in_valid && flux_queue.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) bucket_regs[i] = 0;
		bucket_regs[REG_ICPT_CAP]   = RST_ICPT_CAP;
		bucket_regs[REG_INFIL_COEF] = RST_INFIL_COEF;
		bucket_regs[REG_INFIL_SHP]  = RST_INFIL_SHP;
		bucket_regs[REG_SOIL_CAP]   = RST_SOIL_CAP;
		bucket_regs[REG_IFLOW_FRAC] = RST_IFLOW_FRAC;
		bucket_regs[REG_RECH_FRAC]  = RST_RECH_FRAC;
		bucket_regs[REG_BASE_FRAC]  = RST_BASE_FRAC;
		soil_level     = RST_SOIL_CAP / 2;
		ground_level   = 0;
		awaiting_first = 1'b1;
		build_exp_tables();
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed days at reset settings; the first one only primes the stores.
		add_day(26'h3FFFFFF, 26'h3FFFFFF);
		add_day(0, 0);
		add_day(26'h3FFFFFF, 0);
		add_day(0, 26'h3FFFFFF);
		add_day(26'h3FFFFFF, 26'h3FFFFFF);
		add_day(26'h3FFFFFF, 26'h3FFFFFF);
		add_day(1, 1);
		add_day(50 << 16, 1 << 16);
		add_day(200 << 16, 5 << 16);
		add_day(0, 60 << 16);
		add_day(0, 60 << 16);
		add_day(26'h2AAAAAA, 26'h1555555);
		add_day(26'h1555555, 26'h2AAAAAA);
		drain();

		// Largest settings but a zero baseflow fraction, with the soil filled and groundwater driven to saturation.
		write_all(655360, 65536000, 1310720, 131072000, 65536, 65536, 0);
		send_idle_pct = 59;
		for (int i = 0; i < 12; i++) add_day(26'h3FFFFFF, 0);
		add_random_days(150);
		drain();

		// Smallest settings plus an ignored write to an unused index.
		write_all(0, 0, 0, 65536, 0, 0, 0);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data  <= '1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 59;
		add_random_days(150);
		drain();

		// Random settings inside the documented ranges.
		for (int p = 0; p < 3; p++) begin
			write_all($urandom_range(0, 655360), $urandom_range(0, 65536000),
				$urandom_range(0, 1310720), $urandom_range(65536, 131072000),
				$urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536));
			send_idle_pct  = 37;
			recv_stall_pct = 37;
			add_random_days(100);
			drain();
		end

		// Zero soil capacity, fractions above one and all-ones fields, under back-pressure.
		write_all(20'hFFFFF, 26'h3FFFFFF, 21'h1FFFFF, 0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		add_random_days(60);
		drain();

		// Back to the reset values, with a soil capacity of all ones and a baseflow fraction above one.
		write_all(RST_ICPT_CAP, RST_INFIL_COEF, RST_INFIL_SHP, 27'h7FFFFFF,
			RST_IFLOW_FRAC, RST_RECH_FRAC, 70000);
		add_random_days(215);
		drain();

		$display("Run covered %0d days and %0d result beats over eight register settings,",
			days_sent, results_seen);
		$display("including extremes, zero soil capacity and a long receiver hold-off.");
		if (!failed) begin
			$display("** rainfall_runoff_bucket_step_top: PASSED **");
		end else begin
			$display("%0d field mismatches", mismatches);
			$display("** rainfall_runoff_bucket_step_top: FAILED **");
		end
		$finish;
	end

endmodule

>>> rainfall_runoff_bucket_step_top.f
sv/rrb_pkg.sv
sv/rrb_div.sv
sv/rrb_dp.sv
sv/rrb_ctrl.sv
sv/rainfall_runoff_bucket_step_top.sv
tb/tb_rainfall_runoff_bucket_step_top.sv
